@@ rtl/core/tcw_pkg.sv @@
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int BOTTOM     = (ROWS - 1) * COLUMNS;

  localparam int ADDR_W   = $clog2(CELL_COUNT);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS + 1);
  localparam int CURSOR_W = 11;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = CHAR_W + ATTR_W;
  localparam int MODE_W   = 2;
  localparam int ROWSEL_W = 5;
  localparam int COLSEL_W = 7;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [0:0] REG_TEXT_ATTR = 1'b0;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_COPY,
    ST_BLANK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
  } mem_req_t;

  typedef struct packed {
    logic                scrolled;
    logic [CURSOR_W-1:0] cursor_index;
    logic [ATTR_W-1:0]   cell_attr;
    logic [CHAR_W-1:0]   cell_char;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/tcw_cell_ram.sv @@
`default_nettype none
module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/tcw_apb_regs.sv @@
`default_nettype none
module tcw_apb_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output logic      [tcw_pkg::ATTR_W-1:0] text_attr
);

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready && (paddr[2] == tcw_pkg::REG_TEXT_ATTR);

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= tcw_pkg::ATTR_RESET;
    end else if (wr_hit) begin
      text_attr <= pwdata[tcw_pkg::ATTR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == tcw_pkg::REG_TEXT_ATTR) begin
      prdata = {{(32 - tcw_pkg::ATTR_W){1'b0}}, text_attr};
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/tcw_engine.sv @@
`default_nettype none
module tcw_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [tcw_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [tcw_pkg::CHAR_W-1:0]   in_char,
  input  wire logic [tcw_pkg::ROWSEL_W-1:0] in_row,
  input  wire logic [tcw_pkg::COLSEL_W-1:0] in_col,
  input  wire logic [tcw_pkg::ATTR_W-1:0]   text_attr,
  input  wire logic                        res_room,
  output logic                             res_push,
  output tcw_pkg::result_t                 res,
  output tcw_pkg::mem_req_t                mem_req,
  input  wire logic [tcw_pkg::CELL_W-1:0]   mem_rdata
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int CW = tcw_pkg::CURSOR_W;
  localparam int RW = tcw_pkg::ROW_W;
  localparam int LW = tcw_pkg::COL_W;

  tcw_pkg::state_t  state, state_next;
  logic [AW-1:0]    sweep, sweep_next;
  logic [RW-1:0]    cur_row, cur_row_next;
  logic [LW-1:0]    cur_col, cur_col_next;
  logic [CW-1:0]    cur_lin, cur_lin_next;
  logic             pend_put, pend_put_next;
  logic [tcw_pkg::CELL_W-1:0] pend_cell, pend_cell_next;
  tcw_pkg::result_t res_next;
  logic             take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tcw_pkg::ST_INIT;
      sweep   <= '0;
      cur_row <= '0;
      cur_col <= '0;
      cur_lin <= '0;
    end else begin
      state   <= state_next;
      sweep   <= sweep_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      cur_lin <= cur_lin_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_put  <= pend_put_next;
    pend_cell <= pend_cell_next;
    res       <= res_next;
  end

  always_comb begin
    state_next     = state;
    sweep_next     = sweep;
    cur_row_next   = cur_row;
    cur_col_next   = cur_col;
    cur_lin_next   = cur_lin;
    pend_put_next  = pend_put;
    pend_cell_next = pend_cell;
    res_next       = res;
    mem_req        = '0;
    res_push       = 1'b0;
    in_ready       = 1'b0;
    take           = 1'b0;

    unique case (state)
      tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = sweep;
        if (sweep == AW'(tcw_pkg::CELL_COUNT - 1)) begin
          sweep_next = '0;
          state_next = (state == tcw_pkg::ST_INIT) ? tcw_pkg::ST_IDLE : tcw_pkg::ST_RESP;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end

      tcw_pkg::ST_IDLE, tcw_pkg::ST_RESP: begin
        in_ready = (state == tcw_pkg::ST_IDLE) || res_room;
        res_push = (state == tcw_pkg::ST_RESP) && res_room;
        take     = in_valid && in_ready;
        if (res_push) begin
          state_next = tcw_pkg::ST_IDLE;
        end
        if (take) begin
          res_next   = '0;
          state_next = tcw_pkg::ST_RESP;
          case (in_mode)
            tcw_pkg::MODE_PUT: begin
              if (in_char == tcw_pkg::NEWLINE_CODE) begin
                if (cur_row >= RW'(tcw_pkg::ROWS - 1)) begin
                  state_next        = tcw_pkg::ST_COPY;
                  sweep_next        = '0;
                  pend_put_next     = 1'b0;
                  cur_row_next      = RW'(tcw_pkg::ROWS - 1);
                  cur_col_next      = '0;
                  cur_lin_next      = CW'(tcw_pkg::BOTTOM);
                  res_next.scrolled = 1'b1;
                end else begin
                  cur_row_next = cur_row + 1'b1;
                  cur_col_next = '0;
                  cur_lin_next = cur_lin - CW'(cur_col) + CW'(tcw_pkg::COLUMNS);
                end
              end else if (in_char != '0) begin
                if (cur_row == RW'(tcw_pkg::ROWS)) begin
                  state_next        = tcw_pkg::ST_COPY;
                  sweep_next        = '0;
                  pend_put_next     = 1'b1;
                  pend_cell_next    = {text_attr, in_char};
                  cur_row_next      = RW'(tcw_pkg::ROWS - 1);
                  cur_col_next      = LW'(1);
                  cur_lin_next      = CW'(tcw_pkg::BOTTOM + 1);
                  res_next.scrolled = 1'b1;
                end else begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = AW'(cur_lin);
                  mem_req.wr_data = {text_attr, in_char};
                  cur_lin_next    = cur_lin + 1'b1;
                  if (cur_col == LW'(tcw_pkg::COLUMNS - 1)) begin
                    cur_col_next = '0;
                    cur_row_next = cur_row + 1'b1;
                  end else begin
                    cur_col_next = cur_col + 1'b1;
                  end
                end
              end
            end
            tcw_pkg::MODE_READ: begin
              if ((32'(in_row) < tcw_pkg::ROWS) && (32'(in_col) < tcw_pkg::COLUMNS)) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = AW'(32'(in_row) * tcw_pkg::COLUMNS + 32'(in_col));
                state_next      = tcw_pkg::ST_READ;
              end
            end
            tcw_pkg::MODE_CLEAR: begin
              state_next   = tcw_pkg::ST_CLEAR;
              sweep_next   = '0;
              cur_row_next = '0;
              cur_col_next = '0;
              cur_lin_next = '0;
            end
            default: begin
            end
          endcase
          res_next.cursor_index = cur_lin_next;
        end
      end

      tcw_pkg::ST_READ: begin
        res_next.cell_char = mem_rdata[tcw_pkg::CHAR_W-1:0];
        res_next.cell_attr = mem_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        state_next         = tcw_pkg::ST_RESP;
      end

      tcw_pkg::ST_COPY: begin
        if (sweep != AW'(tcw_pkg::BOTTOM)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = sweep + AW'(tcw_pkg::COLUMNS);
        end
        if (sweep != '0) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = sweep - 1'b1;
          mem_req.wr_data = mem_rdata;
        end
        if (sweep == AW'(tcw_pkg::BOTTOM)) begin
          state_next = tcw_pkg::ST_BLANK;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end

      tcw_pkg::ST_BLANK: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = sweep;
        if (pend_put && (sweep == AW'(tcw_pkg::BOTTOM))) begin
          mem_req.wr_data = pend_cell;
        end
        if (sweep == AW'(tcw_pkg::CELL_COUNT - 1)) begin
          sweep_next = '0;
          state_next = tcw_pkg::ST_RESP;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end

      default: begin
        state_next = tcw_pkg::ST_INIT;
        sweep_next = '0;
      end
    endcase
  end

  a_cursor_consistent: assert property (@(posedge clk) disable iff (rst)
    cur_lin == CW'(32'(cur_row) * tcw_pkg::COLUMNS + 32'(cur_col)))
    else $error("linear cursor disagrees with row and column");

  a_past_end_col_zero: assert property (@(posedge clk) disable iff (rst)
    (cur_row == RW'(tcw_pkg::ROWS)) |-> (cur_col == '0))
    else $error("cursor past last cell with nonzero column");

  a_no_same_cell: assert property (@(posedge clk) disable iff (rst)
    (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
    else $error("read and write of the same cell in one cycle");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_room)
    else $error("result pushed without room");

  a_clear_starts: assert property (@(posedge clk) disable iff (rst)
    (take && (in_mode == tcw_pkg::MODE_CLEAR)) |=> (state == tcw_pkg::ST_CLEAR && sweep == '0))
    else $error("clear request did not start the sweep");

endmodule
`default_nettype wire

@@ rtl/core/text_console_writer_core.sv @@
// Text console of ROWS x COLUMNS cells (80x25) held in one single-port-write, one-read
// cell memory with registered read data. A put request for an ordinary character that does
// not scroll, a newline that stays on screen, a zero byte or an unused mode is done in the
// cycle it is accepted, and such requests are accepted back to back while the result stream
// has room. An in-range cell read waits in the READ state for the registered memory read
// data. A put that scrolls copies every row up one entry per cycle and then blanks the
// bottom row; clear screen writes every cell once. After reset the memory is cleared in one
// pass during which no request is accepted; configuration writes are taken at any time.
// One result is returned per request through an output register.
`default_nettype none
module text_console_writer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // char_code[7:0], read_row[12:8], read_col[19:13]
  input  wire logic [1:0]  s_tuser,  // mode[1:0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata   // cell_char[7:0], cell_attr[15:8],
                                     // cursor_index[26:16], scrolled[27]
);

  logic [tcw_pkg::ATTR_W-1:0] text_attr;
  logic                       res_room;
  logic                       res_push;
  tcw_pkg::result_t           res;
  tcw_pkg::mem_req_t          mem_req;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;
  logic                       out_full;
  tcw_pkg::result_t           out_res;

  tcw_apb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .text_attr (text_attr)
  );

  tcw_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_char   (s_tdata[7:0]),
    .in_row    (s_tdata[12:8]),
    .in_col    (s_tdata[19:13]),
    .text_attr (text_attr),
    .res_room  (res_room),
    .res_push  (res_push),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  tcw_cell_ram #(
    .DEPTH (tcw_pkg::CELL_COUNT),
    .WIDTH (tcw_pkg::CELL_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (mem_rdata),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data)
  );

  assign res_room = !out_full || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_push) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_full;
  assign m_tdata  = {4'b0, out_res};

endmodule
`default_nettype wire
